// File: src/ansi_sgr_pkg.sv
// ----------------------------------------------------------------------------
// ansi_sgr_pkg
// Shared types, character codes and color palettes for the SGR attribute
// parser: input and result word layouts, register indexes, parser modes.
// ----------------------------------------------------------------------------
package ansi_sgr_pkg;

  // input word: one text code unit plus end-of-chunk mark
  typedef struct packed {
    logic [15:0] char_code;
    logic        chunk_end;
  } in_item_t;

  // result word: one visible glyph with its attributes
  typedef struct packed {
    logic [15:0] glyph_code;
    logic [2:0]  columns;
    logic [23:0] color_rgb;
    logic        bold;
  } out_item_t;

  // color and bold pair carried through the parser
  typedef struct packed {
    logic [23:0] color;
    logic        bold;
  } attr_t;

  // parser modes
  typedef enum logic [2:0] {
    MODE_TEXT = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_CSI  = 3'b100
  } mode_t;

  // register indexes
  localparam logic CFG_BASE_COLOR   = 1'b0;
  localparam logic CFG_DARK_PALETTE = 1'b1;

  // register reset values
  localparam logic [23:0] BASE_COLOR_RST   = 24'hD8DCE0;
  localparam logic        DARK_PALETTE_RST = 1'b1;

  // character codes
  localparam logic [15:0] CH_TAB       = 16'h0009;
  localparam logic [15:0] CH_LF        = 16'h000A;
  localparam logic [15:0] CH_ESC       = 16'h001B;
  localparam logic [15:0] CH_SPACE     = 16'h0020;
  localparam logic [15:0] CH_SEMICOLON = 16'h003B;
  localparam logic [15:0] CH_LBRACKET  = 16'h005B;
  localparam logic [15:0] CH_FINAL_M   = 16'h006D;

  // param handling
  localparam int unsigned PARAM_W  = 14;
  localparam logic [PARAM_W-1:0] PARAM_MAX = 14'd16383;

  // sgr codes
  localparam logic [PARAM_W-1:0] SGR_RESET    = 14'd0;
  localparam logic [PARAM_W-1:0] SGR_BOLD     = 14'd1;
  localparam logic [PARAM_W-1:0] SGR_NORMAL   = 14'd22;
  localparam logic [PARAM_W-1:0] SGR_FG_DFLT  = 14'd39;
  localparam logic [PARAM_W-1:0] SGR_BG_DFLT  = 14'd49;
  localparam logic [PARAM_W-1:0] SGR_FG_LO    = 14'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI    = 14'd37;
  localparam logic [PARAM_W-1:0] SGR_FG_BR_LO = 14'd90;
  localparam logic [PARAM_W-1:0] SGR_FG_BR_HI = 14'd97;

  // dark-background palette, dark entries then bright entries
  localparam logic [23:0] PAL_DARK [16] = '{
    24'h5C6370, 24'hE06C75, 24'h98C379, 24'hE5C07B,
    24'h61AFEF, 24'hC678DD, 24'h56B6C2, 24'hD8DCE0,
    24'h7F848E, 24'hF07178, 24'hA6E3A1, 24'hF9E2AF,
    24'h82AAFF, 24'hD3869B, 24'h89DDFF, 24'hFFFFFF
  };

  // light-background palette
  localparam logic [23:0] PAL_LIGHT [16] = '{
    24'h383A42, 24'hE45649, 24'h50A14F, 24'h986801,
    24'h4078F2, 24'hA626A4, 24'h0184BC, 24'hA0A1A7,
    24'h696C77, 24'hCA1243, 24'h50A14F, 24'h986801,
    24'h4078F2, 24'hA626A4, 24'h0184BC, 24'h282C34
  };

  // palette lookup
  function automatic logic [23:0] pal_color(logic dark, logic [3:0] idx);
    return dark ? PAL_DARK[idx] : PAL_LIGHT[idx];
  endfunction

  // apply one sgr code to the attributes being built
  function automatic attr_t apply_code(logic [PARAM_W-1:0] v, attr_t a,
                                       logic [23:0] base, logic dark);
    attr_t r;
    r = a;
    if (v == SGR_RESET) begin
      r.color = base;
      r.bold  = 1'b0;
    end else if (v == SGR_BOLD) begin
      r.bold = 1'b1;
    end else if (v == SGR_NORMAL) begin
      r.bold = 1'b0;
    end else if (v == SGR_FG_DFLT || v == SGR_BG_DFLT) begin
      r.color = base;
    end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
      r.color = pal_color(dark, 4'(v - SGR_FG_LO));
    end else if (v >= SGR_FG_BR_LO && v <= SGR_FG_BR_HI) begin
      r.color = pal_color(dark, 4'(v - SGR_FG_BR_LO + 14'd8));
    end
    return r;
  endfunction

endpackage

// File: src/ansi_sgr_attribute_parser_unit.sv
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser_unit
// Text stream filter that strips ESC [ ... sequences, tracks the SGR color
// and bold attributes and emits visible glyphs tagged with those attributes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one 16-bit code unit per word plus a chunk_end mark. The unit
//           that carries chunk_end is handled normally, then the parser and
//           attributes return to their reset state.
//   out_* : one word per visible unit (printable, newline or tab) with its
//           width, color and bold flag; escape sequences, ESC, CR and other
//           control units give no word.
//   cfg_* : register writes (index 0 base color, index 1 palette select),
//           always ready; issue them only while the stream is idle.
// Timing: a word accepted at one edge is visible on out_* after that edge if
//   out_* is free or being read. One word is accepted per cycle while in_ready
//   is high; the parser state updates per word, with no internal throughput limit.
// Stall: results sit in an output register backed by one skid register;
//   in_ready drops only while the skid register is full, so words are still
//   taken while the receiver holds out_ready low until one more result fills it.
// Reset: synchronous; clears the parser to text mode, attributes to the
//   base color with bold off, and the registers to their defaults.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ansi_sgr_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ansi_sgr_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [23:0]            cfg_data
);

  // configuration registers
  logic [23:0] base_color;
  logic        dark_palette;

  // parser state
  ansi_sgr_pkg::mode_t mode, mode_next;
  ansi_sgr_pkg::attr_t cur_attr, cur_attr_next;
  ansi_sgr_pkg::attr_t pend_attr, pend_attr_next;
  logic [ansi_sgr_pkg::PARAM_W-1:0] param_value, param_value_next;
  logic p_nonempty, p_nonempty_next;
  logic p_bad, p_bad_next;
  logic p_seen, p_seen_next;

  // output register and skid register
  ansi_sgr_pkg::out_item_t skid_data;
  logic skid_valid;

  // datapath helpers
  logic                  in_fire;
  logic                  pop;
  logic                  push;
  logic [15:0]           c;
  logic                  is_letter;
  logic                  is_digit;
  logic [17:0]           acc;
  logic                  text_emit;
  ansi_sgr_pkg::attr_t   closed_attr;
  ansi_sgr_pkg::attr_t   final_attr;
  logic [ansi_sgr_pkg::PARAM_W-1:0] closed_code;
  ansi_sgr_pkg::out_item_t result;

  assign in_fire   = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign c         = in_data.char_code;

  // character classes
  always_comb begin
    is_letter = c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]};
    is_digit  = c inside {[16'h0030:16'h0039]};
  end

  // digit accumulate with saturation
  always_comb begin
    acc = {1'b0, param_value, 3'b000} + {3'b000, param_value, 1'b0} + {14'd0, c[3:0]};
    if (acc > {4'd0, ansi_sgr_pkg::PARAM_MAX}) begin
      acc = {4'd0, ansi_sgr_pkg::PARAM_MAX};
    end
  end

  // closing the current param
  always_comb begin
    closed_code = p_bad ? ansi_sgr_pkg::SGR_RESET : param_value;
    closed_attr = p_nonempty
                ? ansi_sgr_pkg::apply_code(closed_code, pend_attr, base_color, dark_palette)
                : pend_attr;
    final_attr  = (p_seen || p_nonempty)
                ? closed_attr
                : ansi_sgr_pkg::apply_code(ansi_sgr_pkg::SGR_RESET, closed_attr,
                                           base_color, dark_palette);
  end

  // text unit handling
  always_comb begin
    text_emit          = (c != ansi_sgr_pkg::CH_ESC) &&
                         (c == ansi_sgr_pkg::CH_TAB || c == ansi_sgr_pkg::CH_LF ||
                          c >= ansi_sgr_pkg::CH_SPACE);
    result.glyph_code  = c;
    result.columns     = (c == ansi_sgr_pkg::CH_TAB) ? 3'd4 : 3'd1;
    result.color_rgb   = cur_attr.color;
    result.bold        = cur_attr.bold;
  end

  // parser next state
  always_comb begin
    mode_next        = mode;
    cur_attr_next    = cur_attr;
    pend_attr_next   = pend_attr;
    param_value_next = param_value;
    p_nonempty_next  = p_nonempty;
    p_bad_next       = p_bad;
    p_seen_next      = p_seen;
    push             = 1'b0;
    case (mode)
      ansi_sgr_pkg::MODE_ESC: begin
        if (c == ansi_sgr_pkg::CH_LBRACKET) begin
          mode_next        = ansi_sgr_pkg::MODE_CSI;
          pend_attr_next   = cur_attr;
          param_value_next = '0;
          p_nonempty_next  = 1'b0;
          p_bad_next       = 1'b0;
          p_seen_next      = 1'b0;
        end else begin
          mode_next = (c == ansi_sgr_pkg::CH_ESC) ? ansi_sgr_pkg::MODE_ESC
                                                  : ansi_sgr_pkg::MODE_TEXT;
          push      = text_emit;
        end
      end
      ansi_sgr_pkg::MODE_CSI: begin
        if (is_letter) begin
          if (c == ansi_sgr_pkg::CH_FINAL_M) begin
            cur_attr_next  = final_attr;
            pend_attr_next = final_attr;
          end
          mode_next        = ansi_sgr_pkg::MODE_TEXT;
          param_value_next = '0;
          p_nonempty_next  = 1'b0;
          p_bad_next       = 1'b0;
          p_seen_next      = 1'b0;
        end else if (c == ansi_sgr_pkg::CH_SEMICOLON) begin
          pend_attr_next   = closed_attr;
          p_seen_next      = p_seen || p_nonempty;
          p_nonempty_next  = 1'b0;
          p_bad_next       = 1'b0;
          param_value_next = '0;
        end else begin
          p_nonempty_next = 1'b1;
          if (is_digit) begin
            param_value_next = acc[ansi_sgr_pkg::PARAM_W-1:0];
          end else begin
            p_bad_next = 1'b1;
          end
        end
      end
      default: begin
        mode_next = (c == ansi_sgr_pkg::CH_ESC) ? ansi_sgr_pkg::MODE_ESC
                                                : ansi_sgr_pkg::MODE_TEXT;
        push      = text_emit;
      end
    endcase
    // chunk end returns everything to reset
    if (in_data.chunk_end) begin
      mode_next        = ansi_sgr_pkg::MODE_TEXT;
      cur_attr_next    = '{color: base_color, bold: 1'b0};
      pend_attr_next   = '{color: base_color, bold: 1'b0};
      param_value_next = '0;
      p_nonempty_next  = 1'b0;
      p_bad_next       = 1'b0;
      p_seen_next      = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_color   <= ansi_sgr_pkg::BASE_COLOR_RST;
      dark_palette <= ansi_sgr_pkg::DARK_PALETTE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ansi_sgr_pkg::CFG_BASE_COLOR:   base_color   <= cfg_data;
        ansi_sgr_pkg::CFG_DARK_PALETTE: dark_palette <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ansi_sgr_pkg::MODE_TEXT;
      cur_attr    <= '{color: ansi_sgr_pkg::BASE_COLOR_RST, bold: 1'b0};
      pend_attr   <= '{color: ansi_sgr_pkg::BASE_COLOR_RST, bold: 1'b0};
      param_value <= '0;
      p_nonempty  <= 1'b0;
      p_bad       <= 1'b0;
      p_seen      <= 1'b0;
    end else if (in_fire) begin
      mode        <= mode_next;
      cur_attr    <= cur_attr_next;
      pend_attr   <= pend_attr_next;
      param_value <= param_value_next;
      p_nonempty  <= p_nonempty_next;
      p_bad       <= p_bad_next;
      p_seen      <= p_seen_next;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || pop) begin
        out_valid <= in_fire && push;
      end else if (in_fire && push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || pop) begin
      out_data <= result;
    end else begin
      skid_data <= result;
    end
  end

  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // skid fills only when the receiver stalled a waiting result
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid ##1 skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled without a stalled result");

  // chunk end returns the parser to plain text with bold off
  a_chunk_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.chunk_end) |=>
      (mode == ansi_sgr_pkg::MODE_TEXT && !cur_attr.bold && !p_nonempty && !p_seen))
    else $error("parser state not cleared after chunk end");

  // no glyph comes out of a word taken inside a sequence
  a_no_emit_in_csi: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == ansi_sgr_pkg::MODE_CSI && !out_valid) |=> !out_valid)
    else $error("result produced from inside an escape sequence");

endmodule

// File: dv/tb_ansi_sgr_attribute_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_ansi_sgr_attribute_parser_unit
// Self-checking bench for the SGR attribute parser. A cycle-free predictor
// tracks parser mode, attributes and registers and queues the glyph words
// each accepted input word causes; a monitor compares every output word
// field by field. Directed sequences come first, then random text mixed
// with well-formed and broken escape sequences under three idle profiles.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_attribute_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // extra character codes
  localparam logic [15:0] CH_CR      = 16'h000D;
  localparam logic [15:0] CH_ZERO    = 16'h0030;
  localparam logic [15:0] CH_NINE    = 16'h0039;
  localparam logic [15:0] CH_UPPER_A = 16'h0041;
  localparam logic [15:0] CH_UPPER_Z = 16'h005A;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;
  localparam logic [15:0] CH_LOWER_Z = 16'h007A;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 20;

  // palettes, dark entries then bright entries
  localparam logic [23:0] DARK_RGB [16] = '{
    24'h5C6370, 24'hE06C75, 24'h98C379, 24'hE5C07B,
    24'h61AFEF, 24'hC678DD, 24'h56B6C2, 24'hD8DCE0,
    24'h7F848E, 24'hF07178, 24'hA6E3A1, 24'hF9E2AF,
    24'h82AAFF, 24'hD3869B, 24'h89DDFF, 24'hFFFFFF
  };
  localparam logic [23:0] LIGHT_RGB [16] = '{
    24'h383A42, 24'hE45649, 24'h50A14F, 24'h986801,
    24'h4078F2, 24'hA626A4, 24'h0184BC, 24'hA0A1A7,
    24'h696C77, 24'hCA1243, 24'h50A14F, 24'h986801,
    24'h4078F2, 24'hA626A4, 24'h0184BC, 24'h282C34
  };

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  ansi_sgr_pkg::in_item_t  in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  ansi_sgr_pkg::out_item_t out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = ansi_sgr_pkg::CFG_BASE_COLOR;
  logic [23:0]             cfg_data  = '0;

  ansi_sgr_attribute_parser_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  ansi_sgr_pkg::mode_t m_mode;
  ansi_sgr_pkg::attr_t m_cur;
  ansi_sgr_pkg::attr_t m_pend;
  logic [13:0]  m_param;
  logic         m_nonempty;
  logic         m_bad;
  logic         m_seen;
  logic [23:0]  m_base;
  logic         m_dark;

  ansi_sgr_pkg::out_item_t exp_glyph_q[$];
  ansi_sgr_pkg::in_item_t  burst_q[$];
  int           err_count     = 0;
  int           src_idle_pct  = 0;
  int           sink_idle_pct = 0;
  int           stall_cycles  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(logic [15:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic [23:0] palette_rgb(int idx);
    return m_dark ? DARK_RGB[idx] : LIGHT_RGB[idx];
  endfunction

  task automatic clear_param();
    m_param    = '0;
    m_nonempty = 1'b0;
    m_bad      = 1'b0;
  endtask

  task automatic clear_parser();
    m_mode = ansi_sgr_pkg::MODE_TEXT;
    m_cur  = '{color: m_base, bold: 1'b0};
    m_pend = m_cur;
    clear_param();
    m_seen = 1'b0;
  endtask

  // one sgr code onto the attributes being built
  task automatic sgr_code(input logic [13:0] v);
    if (v == ansi_sgr_pkg::SGR_RESET) begin
      m_pend.color = m_base;
      m_pend.bold  = 1'b0;
    end else if (v == ansi_sgr_pkg::SGR_BOLD) begin
      m_pend.bold = 1'b1;
    end else if (v == ansi_sgr_pkg::SGR_NORMAL) begin
      m_pend.bold = 1'b0;
    end else if (v == ansi_sgr_pkg::SGR_FG_DFLT || v == ansi_sgr_pkg::SGR_BG_DFLT) begin
      m_pend.color = m_base;
    end else if (v >= ansi_sgr_pkg::SGR_FG_LO && v <= ansi_sgr_pkg::SGR_FG_HI) begin
      m_pend.color = palette_rgb(int'(v - ansi_sgr_pkg::SGR_FG_LO));
    end else if (v >= ansi_sgr_pkg::SGR_FG_BR_LO && v <= ansi_sgr_pkg::SGR_FG_BR_HI) begin
      m_pend.color = palette_rgb(int'(v - ansi_sgr_pkg::SGR_FG_BR_LO) + 8);
    end
  endtask

  // close the current param; a param with a non-digit counts as reset
  task automatic close_param();
    if (m_nonempty) begin
      sgr_code(m_bad ? ansi_sgr_pkg::SGR_RESET : m_param);
      m_seen = 1'b1;
    end
    clear_param();
  endtask

  task automatic emit_text(input logic [15:0] c);
    ansi_sgr_pkg::out_item_t g;
    if (c == ansi_sgr_pkg::CH_ESC) begin
      m_mode = ansi_sgr_pkg::MODE_ESC;
    end else if (c == ansi_sgr_pkg::CH_TAB || c == ansi_sgr_pkg::CH_LF ||
                 c >= ansi_sgr_pkg::CH_SPACE) begin
      g.glyph_code = c;
      g.columns    = (c == ansi_sgr_pkg::CH_TAB) ? 3'd4 : 3'd1;
      g.color_rgb  = m_cur.color;
      g.bold       = m_cur.bold;
      exp_glyph_q.push_back(g);
    end
  endtask

  task automatic predict_glyph(input ansi_sgr_pkg::in_item_t w);
    logic [15:0] c;
    int          acc;
    c = w.char_code;
    case (m_mode)
      ansi_sgr_pkg::MODE_ESC: begin
        if (c == ansi_sgr_pkg::CH_LBRACKET) begin
          m_mode = ansi_sgr_pkg::MODE_CSI;
          m_pend = m_cur;
          clear_param();
          m_seen = 1'b0;
        end else begin
          m_mode = ansi_sgr_pkg::MODE_TEXT;
          emit_text(c);
        end
      end
      ansi_sgr_pkg::MODE_CSI: begin
        if (is_letter(c)) begin
          if (c == ansi_sgr_pkg::CH_FINAL_M) begin
            close_param();
            if (!m_seen) sgr_code(ansi_sgr_pkg::SGR_RESET);
            m_cur = m_pend;
          end
          m_mode = ansi_sgr_pkg::MODE_TEXT;
          clear_param();
          m_seen = 1'b0;
        end else if (c == ansi_sgr_pkg::CH_SEMICOLON) begin
          close_param();
        end else begin
          // every other unit, controls and ESC too, is part of the param
          m_nonempty = 1'b1;
          if (c >= CH_ZERO && c <= CH_NINE) begin
            acc     = int'(m_param) * 10 + int'(c - CH_ZERO);
            m_param = (acc > int'(ansi_sgr_pkg::PARAM_MAX)) ? ansi_sgr_pkg::PARAM_MAX
                                                            : 14'(acc);
          end else begin
            m_bad = 1'b1;
          end
        end
      end
      default: emit_text(c);
    endcase
    if (w.chunk_end) clear_parser();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // compare each output word with the oldest expected glyph
  always @(posedge clk) begin : check_glyph
    ansi_sgr_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (exp_glyph_q.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_data.glyph_code), '0);
      end else begin
        want = exp_glyph_q.pop_front();
        if (out_data.glyph_code !== want.glyph_code)
          report_mismatch("glyph_code", 32'(out_data.glyph_code), 32'(want.glyph_code));
        if (out_data.columns !== want.columns)
          report_mismatch("columns", 32'(out_data.columns), 32'(want.columns));
        if (out_data.color_rgb !== want.color_rgb)
          report_mismatch("color_rgb", 32'(out_data.color_rgb), 32'(want.color_rgb));
        if (out_data.bold !== want.bold)
          report_mismatch("bold", 32'(out_data.bold), 32'(want.bold));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[ansi_sgr_attribute_parser_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input ansi_sgr_pkg::in_item_t w);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_glyph(w);
  endtask

  // send the queued words; chunk_end is set at random on end_pct of them
  task automatic send_burst(input int end_pct);
    ansi_sgr_pkg::in_item_t w;
    while (burst_q.size() != 0) begin
      w = burst_q.pop_front();
      if (end_pct != 0 && $urandom_range(99) < end_pct) w.chunk_end = 1'b1;
      send_word(w);
    end
  endtask

  // stop sending and wait until every expected glyph has come out
  task automatic drain_glyphs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_glyph_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ansi_sgr_pkg::CFG_BASE_COLOR) m_base = value;
    else m_dark = value[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_unit(input logic [15:0] c);
    burst_q.push_back('{char_code: c, chunk_end: 1'b0});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_unit({8'h00, s[i]});
  endtask

  task automatic push_number(input int unsigned n);
    push_str($sformatf("%0d", n));
  endtask

  function automatic logic [15:0] random_text_unit();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(32'h20, 32'h7E));
      5:             return ansi_sgr_pkg::CH_TAB;
      6:             return ansi_sgr_pkg::CH_LF;
      7:             return 16'($urandom_range(0, 31));
      8:             return 16'($urandom());
      default:       return ansi_sgr_pkg::CH_ESC;
    endcase
  endfunction

  // a unit that is neither a letter, a digit nor a separator
  function automatic logic [15:0] random_junk_unit();
    logic [15:0] c;
    do begin
      c = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom());
    end while (is_letter(c) || c == ansi_sgr_pkg::CH_SEMICOLON ||
               (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  function automatic logic [13:0] random_sgr_code();
    case ($urandom_range(6))
      0:       return ansi_sgr_pkg::SGR_RESET;
      1:       return ansi_sgr_pkg::SGR_BOLD;
      2:       return ansi_sgr_pkg::SGR_NORMAL;
      3:       return ansi_sgr_pkg::SGR_FG_DFLT;
      4:       return ansi_sgr_pkg::SGR_BG_DFLT;
      5:       return ansi_sgr_pkg::SGR_FG_LO + 14'($urandom_range(7));
      default: return ansi_sgr_pkg::SGR_FG_BR_LO + 14'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [15:0] random_letter();
    return ($urandom_range(1) == 0) ? CH_UPPER_A + 16'($urandom_range(25))
                                    : CH_LOWER_A + 16'($urandom_range(25));
  endfunction

  // escape sequence, mostly well formed, sometimes broken
  task automatic build_sgr_burst();
    int n_params;
    n_params = $urandom_range(0, 4);
    push_unit(ansi_sgr_pkg::CH_ESC);
    if ($urandom_range(9) == 0) begin
      // lone escape
      push_unit(random_text_unit());
    end else begin
      push_unit(ansi_sgr_pkg::CH_LBRACKET);
      for (int i = 0; i < n_params; i++) begin
        if (i != 0) push_unit(ansi_sgr_pkg::CH_SEMICOLON);
        case ($urandom_range(9))
          0, 1, 2, 3, 4: push_number(random_sgr_code());
          5:             push_number($urandom_range(0, 199));
          6: begin
            case ($urandom_range(2))
              0:       push_number(ansi_sgr_pkg::PARAM_MAX);
              1:       push_number(ansi_sgr_pkg::PARAM_MAX + 1);
              default: push_number($urandom_range(10000, 999999));
            endcase
          end
          7: ;  // empty param
          8: begin
            if ($urandom_range(1) == 0) push_number($urandom_range(0, 99));
            push_unit(random_junk_unit());
            if ($urandom_range(1) == 0) push_number($urandom_range(0, 9));
          end
          default: begin
            push_unit(CH_ZERO);
            push_number(random_sgr_code());
          end
        endcase
      end
      // final: mostly m, sometimes another letter, rarely left open
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: push_unit(ansi_sgr_pkg::CH_FINAL_M);
        7, 8:                push_unit(random_letter());
        default: ;
      endcase
    end
  endtask

  task automatic build_text_run();
    repeat ($urandom_range(1, 6)) push_unit(random_text_unit());
  endtask

  task automatic run_random_phase(input int n_items, input int src_pct, input int sink_pct);
    int sent;
    bit paused;
    sent          = 0;
    paused        = 1'b0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) build_text_run();
      else build_sgr_burst();
      sent += burst_q.size();
      send_burst(2);
      // hold off once mid-phase until the output side is empty
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        drain_glyphs();
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // field extremes, tab, newline and dropped control units
  task automatic test_plain_units();
    push_unit(ansi_sgr_pkg::CH_SPACE);
    push_unit(16'hFFFF);
    push_unit(ansi_sgr_pkg::CH_TAB);
    push_unit(ansi_sgr_pkg::CH_LF);
    push_unit(CH_CR);
    push_unit(16'h0000);
    push_unit(16'h001F);
    send_burst(0);
  endtask

  task automatic test_sgr_sequences();
    // lone escape, then escape after escape
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("q");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[1;;95mb");
    // saturated param and unknown code change nothing
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[16384;7mc");
    // malformed param resets, other final discards
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[3!md");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[31He");
    // empty sequence, then an open one cut by chunk end
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[1m");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[mf");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[3");
    burst_q[$].chunk_end = 1'b1;
    push_str("g");
    send_burst(0);
  endtask

  // base color and palette written while a chunk is still open
  task automatic test_config_mid_chunk();
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[1;32mx");
    send_burst(0);
    drain_glyphs();
    write_reg(ansi_sgr_pkg::CFG_BASE_COLOR, 24'h000000);
    write_reg(ansi_sgr_pkg::CFG_DARK_PALETTE, 24'd0);
    push_str("y");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[33mz");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[39mw");
    push_unit(ansi_sgr_pkg::CH_ESC);
    push_str("[mv");
    burst_q[$].chunk_end = 1'b1;
    send_burst(0);
  endtask

  task automatic test_random_slow_sink();
    drain_glyphs();
    write_reg(ansi_sgr_pkg::CFG_BASE_COLOR, ansi_sgr_pkg::BASE_COLOR_RST);
    write_reg(ansi_sgr_pkg::CFG_DARK_PALETTE, 24'd1);
    run_random_phase(500, 9, 55);
  endtask

  task automatic test_random_slow_source();
    drain_glyphs();
    write_reg(ansi_sgr_pkg::CFG_BASE_COLOR, 24'hFFFFFF);
    write_reg(ansi_sgr_pkg::CFG_DARK_PALETTE, 24'd0);
    run_random_phase(500, 55, 9);
  endtask

  task automatic test_random_full_rate();
    drain_glyphs();
    write_reg(ansi_sgr_pkg::CFG_BASE_COLOR, 24'($urandom()));
    write_reg(ansi_sgr_pkg::CFG_DARK_PALETTE, 24'd1);
    run_random_phase(500, 0, 0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    m_base = ansi_sgr_pkg::BASE_COLOR_RST;
    m_dark = ansi_sgr_pkg::DARK_PALETTE_RST;
    clear_parser();
    src_idle_pct  = 9;
    sink_idle_pct = 55;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_plain_units();
    test_sgr_sequences();
    test_config_mid_chunk();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();

    drain_glyphs();
    if (err_count == 0) begin
      $display("[ansi_sgr_attribute_parser_unit] OK");
    end else begin
      $display("[ansi_sgr_attribute_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/ansi_sgr_pkg.sv
src/ansi_sgr_attribute_parser_unit.sv
dv/tb_ansi_sgr_attribute_parser_unit.sv
